// File: rtl/wdt_pkg.sv
// ----------------------------------------------------------------------------
// wdt_pkg
// Shared types and constants of the two-stage watchdog: opcodes, register
// offsets, channel widths and the structs passed between the modules.
// ----------------------------------------------------------------------------
package wdt_pkg;

    // Channel widths
    localparam int unsigned OP_W       = 2;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned COUNT_W    = 64;
    localparam int unsigned S_TDATA_W  = 112;   // 108 bits of fields, byte aligned
    localparam int unsigned S_TUSER_W  = 3;
    localparam int unsigned M_TDATA_W  = 40;    // 34 bits of fields, byte aligned
    localparam int unsigned M_PAD_W    = M_TDATA_W - DATA_W - 2;

    // Bit positions in s_tdata
    localparam int unsigned S_ADDR_LSB  = 0;
    localparam int unsigned S_WDATA_LSB = S_ADDR_LSB + ADDR_W;
    localparam int unsigned S_COUNT_LSB = S_WDATA_LSB + DATA_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    // Frame select
    localparam logic FRAME_CTRL    = 1'b0;
    localparam logic FRAME_REFRESH = 1'b1;

    // Register offsets
    localparam logic [ADDR_W-1:0] ADR_CTRL    = 12'd0;
    localparam logic [ADDR_W-1:0] ADR_OFFSET  = 12'd8;
    localparam logic [ADDR_W-1:0] ADR_CMP_LO  = 12'd16;
    localparam logic [ADDR_W-1:0] ADR_CMP_HI  = 12'd20;
    localparam logic [ADDR_W-1:0] ADR_REFRESH = 12'd0;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               frame;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  wdata;
        logic [COUNT_W-1:0] count;
    } item_t;

    typedef struct packed {
        logic tick;
        logic wr_ctrl;
        logic wr_offset;
        logic wr_cmp_lo;
        logic wr_cmp_hi;
        logic wr_refresh;
        logic rd_ctrl;
        logic rd_offset;
        logic rd_cmp_lo;
        logic rd_cmp_hi;
    } dec_t;

    typedef struct packed {
        logic               stage_two;
        logic               stage_one;
        logic [DATA_W-1:0]  read_data;
    } result_t;

endpackage

// File: rtl/wdt_decode.sv
// ----------------------------------------------------------------------------
// wdt_decode
// Decodes opcode, frame and byte offset of one item into one-hot register
// strobes. Offsets at or past the frame size, or not exactly on a register,
// decode to nothing.
// ----------------------------------------------------------------------------
module wdt_decode #(
    parameter int unsigned FRAME_BYTES = 4096
) (
    input  wdt_pkg::item_t item,
    output wdt_pkg::dec_t  dec
);
    import wdt_pkg::*;

    localparam int unsigned CMP_W = 17;   // holds FRAME_BYTES up to 65536

    logic in_frame;
    logic ctrl_frame;

    assign in_frame   = {{(CMP_W-ADDR_W){1'b0}}, item.addr} < CMP_W'(FRAME_BYTES);
    assign ctrl_frame = (item.frame == FRAME_CTRL);

    always_comb begin
        dec = '0;
        case (item.op)
            OP_TICK: begin
                dec.tick = 1'b1;
            end
            OP_READ: begin
                if (in_frame && ctrl_frame) begin
                    dec.rd_ctrl   = (item.addr == ADR_CTRL);
                    dec.rd_offset = (item.addr == ADR_OFFSET);
                    dec.rd_cmp_lo = (item.addr == ADR_CMP_LO);
                    dec.rd_cmp_hi = (item.addr == ADR_CMP_HI);
                end
            end
            OP_WRITE: begin
                if (in_frame && ctrl_frame) begin
                    dec.wr_ctrl   = (item.addr == ADR_CTRL);
                    dec.wr_offset = (item.addr == ADR_OFFSET);
                    dec.wr_cmp_lo = (item.addr == ADR_CMP_LO);
                    dec.wr_cmp_hi = (item.addr == ADR_CMP_HI);
                end else if (in_frame) begin
                    dec.wr_refresh = (item.addr == ADR_REFRESH);
                end
            end
            default: begin
                dec = '0;
            end
        endcase
    end

endmodule

// File: rtl/wdt_core.sv
// ----------------------------------------------------------------------------
// wdt_core
// Watchdog state (enable, two timeout flags, offset, compare) and its update
// for one decoded item. Produces the result of the item from the new flags.
// ----------------------------------------------------------------------------
module wdt_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  wdt_pkg::dec_t                 dec,
    input  logic [wdt_pkg::DATA_W-1:0]    wdata,
    input  logic [wdt_pkg::COUNT_W-1:0]   count,
    output wdt_pkg::result_t              result
);
    import wdt_pkg::*;

    logic               enabled_reg,  enabled_next;
    logic               first_reg,    first_next;
    logic               second_reg,   second_next;
    logic [DATA_W-1:0]  offset_reg,   offset_next;
    logic [COUNT_W-1:0] compare_reg,  compare_next;

    logic [DATA_W-1:0]  reload_off;
    logic [COUNT_W-1:0] reload;
    logic               expired;
    logic               refresh;
    logic [DATA_W-1:0]  rd;

    // An offset write refreshes with the value being written
    assign reload_off = dec.wr_offset ? wdata : offset_reg;
    assign reload     = count + {{(COUNT_W-DATA_W){1'b0}}, reload_off};
    assign expired    = (count >= compare_reg);
    assign refresh    = dec.wr_ctrl || dec.wr_offset || dec.wr_refresh;

    always_comb begin
        enabled_next = enabled_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        offset_next  = offset_reg;
        compare_next = compare_reg;

        if (dec.tick && enabled_reg && expired) begin
            if (!first_reg) begin
                first_next   = 1'b1;
                compare_next = reload;
            end else begin
                second_next = 1'b1;
            end
        end

        if (dec.wr_ctrl) begin
            enabled_next = wdata[0];
        end
        if (dec.wr_offset) begin
            offset_next = wdata;
        end
        if (refresh) begin
            compare_next = reload;
            first_next   = 1'b0;
            second_next  = 1'b0;
        end
        if (dec.wr_cmp_lo) begin
            compare_next = {compare_reg[COUNT_W-1:DATA_W], wdata};
        end
        if (dec.wr_cmp_hi) begin
            compare_next = {wdata, compare_reg[DATA_W-1:0]};
        end
    end

    always_comb begin
        rd = '0;
        if (dec.rd_ctrl) begin
            rd = {{(DATA_W-3){1'b0}}, second_reg, first_reg, enabled_reg};
        end
        if (dec.rd_offset) begin
            rd = offset_reg;
        end
        if (dec.rd_cmp_lo) begin
            rd = compare_reg[DATA_W-1:0];
        end
        if (dec.rd_cmp_hi) begin
            rd = compare_reg[COUNT_W-1:DATA_W];
        end
    end

    assign result.read_data = rd;
    assign result.stage_one = first_next;
    assign result.stage_two = second_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            first_reg   <= 1'b0;
            second_reg  <= 1'b0;
            offset_reg  <= '0;
            compare_reg <= '0;
        end else if (fire) begin
            enabled_reg <= enabled_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            offset_reg  <= offset_next;
            compare_reg <= compare_next;
        end
    end

endmodule

// File: rtl/two_stage_watchdog_timer.sv
// ----------------------------------------------------------------------------
// two_stage_watchdog_timer
// Two-stage watchdog with a control frame and a refresh frame.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_ transfer is a counter tick, a 32-bit register read or a register
//   write. Every input transfer yields exactly one m_ transfer carrying the
//   read data (zero unless a read hit a register) and both timeout flags as
//   they stand after the item. Stage one drives the interrupt, stage two the
//   system reset.
//   An input transfer passes through one input register, then the decode,
//   the 64-bit reload add and the compare into the result register behind
//   m_tvalid. One item per cycle is sustained while m_tready is high; the
//   state update of one item is complete before the next one is evaluated.
//   If the receiver stalls, the result register holds and the input register
//   still takes one more item; s_tready drops only when both are full.
//   Synchronous reset (aresetn low) empties both registers, disables the
//   watchdog, clears both flags and zeroes offset and compare.
// ----------------------------------------------------------------------------
module two_stage_watchdog_timer #(
    parameter int unsigned FRAME_BYTES = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // byte_address[11:0], write_data[43:12], system_count[107:44], zero pad
    input  logic [wdt_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[1:0], frame[2]
    input  logic [wdt_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_data[31:0], stage_one_signal[32], stage_two_signal[33], zero pad
    output logic [wdt_pkg::M_TDATA_W-1:0]   m_tdata
);
    import wdt_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    item_t   s_item;
    dec_t    dec;
    result_t result;
    logic    s_take;
    logic    out_load;

    assign s_item.op    = s_tuser[OP_W-1:0];
    assign s_item.frame = s_tuser[OP_W];
    assign s_item.addr  = s_tdata[S_ADDR_LSB +: ADDR_W];
    assign s_item.wdata = s_tdata[S_WDATA_LSB +: DATA_W];
    assign s_item.count = s_tdata[S_COUNT_LSB +: COUNT_W];

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
        if (out_load) begin
            out_data_reg <= result;
        end
    end

    wdt_decode #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_decode (
        .item(in_item_reg),
        .dec (dec)
    );

    wdt_core u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .fire   (out_load),
        .dec    (dec),
        .wdata  (in_item_reg.wdata),
        .count  (in_item_reg.count),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_data_reg.stage_two, out_data_reg.stage_one,
                       out_data_reg.read_data};

    // Stage two is only ever reached through stage one
    a_two_needs_one: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.stage_two |-> out_data_reg.stage_one)
        else $error("stage two flag set without stage one flag");

    // A held item is not dropped while the result register is blocked
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_load |=> in_valid_reg)
        else $error("pending item lost while result stage stalled");

    // Only reads return data
    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && (in_item_reg.op != OP_READ) |=> out_data_reg.read_data == '0)
        else $error("nonzero read data on a tick or write");

endmodule

// File: tb/two_stage_watchdog_timer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stage_watchdog_timer_tb
// Self-checking bench for the two-stage watchdog. A driver feeds ticks and
// register reads and writes from a queue in random bursts. A behavioral
// predictor of the watchdog state produces one expected result per input
// transfer. A monitor checks read data and both timeout flags while the
// result side stalls on its own pattern and once for a long stretch.
// ----------------------------------------------------------------------------
module two_stage_watchdog_timer_tb;
    import wdt_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
    localparam int unsigned     IDLE_LIMIT = 5000;
    localparam int unsigned     HOLD_START = 1000;
    localparam int unsigned     HOLD_LEN   = 300;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    two_stage_watchdog_timer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    item_t   pending_items[$];
    result_t expected_results[$];
    item_t   cur_item;
    int      total_items;
    int      items_accepted;
    int      results_checked;
    int      mismatches;

    // Watchdog state as the predictor sees it
    logic        wd_enabled;
    logic        wd_first;
    logic        wd_second;
    logic [31:0] wd_offset;
    logic [63:0] wd_compare;

    int n_ticks, n_reads, n_writes, n_stage_one, n_stage_two;

    initial begin
        wd_enabled = 1'b0;
        wd_first   = 1'b0;
        wd_second  = 1'b0;
        wd_offset  = '0;
        wd_compare = '0;
    end

    function automatic void refresh_watchdog(input logic [63:0] count);
        wd_compare = count + {32'd0, wd_offset};
        wd_first   = 1'b0;
        wd_second  = 1'b0;
    endfunction

    // Applies one transfer to the predicted state and returns its result
    function automatic result_t step_watchdog(input item_t it);
        result_t r;
        r = '0;
        case (it.op)
            OP_TICK: begin
                n_ticks++;
                if (wd_enabled && it.count >= wd_compare) begin
                    if (!wd_first) begin
                        wd_first   = 1'b1;
                        wd_compare = it.count + {32'd0, wd_offset};
                        n_stage_one++;
                    end else begin
                        if (!wd_second) n_stage_two++;
                        wd_second = 1'b1;
                    end
                end
            end
            OP_READ: begin
                n_reads++;
                if (it.frame == FRAME_CTRL) begin
                    case (it.addr)
                        ADR_CTRL:   r.read_data = {29'd0, wd_second, wd_first, wd_enabled};
                        ADR_OFFSET: r.read_data = wd_offset;
                        ADR_CMP_LO: r.read_data = wd_compare[31:0];
                        ADR_CMP_HI: r.read_data = wd_compare[63:32];
                        default:    r.read_data = '0;
                    endcase
                end
            end
            OP_WRITE: begin
                n_writes++;
                if (it.frame == FRAME_REFRESH) begin
                    if (it.addr == ADR_REFRESH) refresh_watchdog(it.count);
                end else begin
                    case (it.addr)
                        ADR_CTRL: begin
                            wd_enabled = it.wdata[0];
                            refresh_watchdog(it.count);
                        end
                        ADR_OFFSET: begin
                            wd_offset = it.wdata;
                            refresh_watchdog(it.count);
                        end
                        ADR_CMP_LO: wd_compare[31:0]  = it.wdata;
                        ADR_CMP_HI: wd_compare[63:32] = it.wdata;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        r.stage_one = wd_first;
        r.stage_two = wd_second;
        return r;
    endfunction

    task automatic queue_item(input logic [OP_W-1:0] op, input logic frame,
                              input logic [ADDR_W-1:0] addr, input logic [31:0] data,
                              input logic [63:0] count);
        item_t it;
        it.op    = op;
        it.frame = frame;
        it.addr  = addr;
        it.wdata = data;
        it.count = count;
        pending_items.push_back(it);
    endtask

    task automatic queue_directed_items();
        // reset values, disabled tick
        queue_item(OP_READ, FRAME_CTRL, ADR_CTRL, 32'hFFFF_FFFF, 64'd0);
        queue_item(OP_READ, FRAME_CTRL, ADR_OFFSET, 32'd0, 64'd0);
        queue_item(OP_READ, FRAME_CTRL, ADR_CMP_HI, 32'd0, 64'd0);
        queue_item(OP_TICK, FRAME_CTRL, ADR_CTRL, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        // arm with offset 100, then walk through both stages
        queue_item(OP_WRITE, FRAME_CTRL, ADR_OFFSET, 32'd100, 64'd1000);
        queue_item(OP_WRITE, FRAME_CTRL, ADR_CTRL, 32'd1, 64'd1000);
        queue_item(OP_TICK, FRAME_CTRL, 12'd0, 32'd0, 64'd1099);
        queue_item(OP_TICK, FRAME_CTRL, 12'd0, 32'd0, 64'd1100);
        queue_item(OP_READ, FRAME_CTRL, ADR_CMP_LO, 32'd0, 64'd1100);
        queue_item(OP_TICK, FRAME_CTRL, 12'd0, 32'd0, 64'd1199);
        queue_item(OP_TICK, FRAME_CTRL, 12'd0, 32'd0, 64'd1200);
        queue_item(OP_READ, FRAME_CTRL, ADR_CTRL, 32'd0, 64'd1200);
        // refresh frame: read is zero, write at a nonzero offset is ignored
        queue_item(OP_READ, FRAME_REFRESH, ADR_REFRESH, 32'd0, 64'd1300);
        queue_item(OP_WRITE, FRAME_REFRESH, 12'd4, 32'd0, 64'd1300);
        queue_item(OP_WRITE, FRAME_REFRESH, ADR_REFRESH, 32'hFFFF_FFFF, 64'd2000);
        // compare words written directly, then a tick at the counter maximum
        queue_item(OP_WRITE, FRAME_CTRL, ADR_CMP_LO, 32'hFFFF_FFFF, 64'd0);
        queue_item(OP_WRITE, FRAME_CTRL, ADR_CMP_HI, 32'hFFFF_FFFF, 64'd0);
        queue_item(OP_TICK, FRAME_REFRESH, 12'hFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_item(OP_READ, FRAME_CTRL, ADR_CMP_HI, 32'd0, 64'd0);
        // wraparound of the reload
        queue_item(OP_WRITE, FRAME_CTRL, ADR_OFFSET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
        queue_item(OP_READ, FRAME_CTRL, ADR_CMP_HI, 32'd0, 64'd0);
        // unaligned and unknown offsets, unused opcode
        queue_item(OP_WRITE, FRAME_CTRL, 12'd9, 32'h1234_5678, 64'd5);
        queue_item(OP_READ, FRAME_CTRL, 12'hFFF, 32'd0, 64'd0);
        queue_item(OP_UNUSED, FRAME_REFRESH, ADR_REFRESH, 32'hFFFF_FFFF, 64'd0);
        // disable with all other bits set
        queue_item(OP_WRITE, FRAME_CTRL, ADR_CTRL, 32'hFFFF_FFFE, 64'd3000);
    endtask

    function automatic logic [ADDR_W-1:0] pick_register();
        case ($urandom_range(0, 3))
            0:       return ADR_CTRL;
            1:       return ADR_OFFSET;
            2:       return ADR_CMP_LO;
            default: return ADR_CMP_HI;
        endcase
    endfunction

    // Mostly well-formed traffic: an advancing counter, small offsets,
    // periodic refreshes, plus a share of arbitrary transfers.
    task automatic queue_random_items(input int n);
        logic [63:0] now;
        logic [31:0] data;
        logic        frame;
        int          kind;
        now = 64'd5000;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 199) == 0) now = {$urandom, $urandom};
            if ($urandom_range(0, 249) == 0)
                now = 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(0, 200));
            frame = ($urandom_range(0, 4) == 0) ? FRAME_REFRESH : FRAME_CTRL;
            if (kind < 45) begin
                now += 64'($urandom_range(0, 6));
                queue_item(OP_TICK, 1'($urandom), 12'($urandom), $urandom, now);
            end else if (kind < 60) begin
                queue_item(OP_READ, frame, pick_register(), $urandom, now);
            end else if (kind < 70) begin
                queue_item(OP_WRITE, FRAME_REFRESH, ADR_REFRESH, $urandom, now);
            end else if (kind < 80) begin
                data = $urandom;
                data[0] = ($urandom_range(0, 7) != 0);
                queue_item(OP_WRITE, FRAME_CTRL, ADR_CTRL, data, now);
            end else if (kind < 85) begin
                data = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
                queue_item(OP_WRITE, FRAME_CTRL, ADR_OFFSET, data, now);
            end else if (kind < 90) begin
                if ($urandom_range(0, 1) == 0) begin
                    data = ($urandom_range(0, 3) == 0) ? $urandom
                                                       : now[31:0] + $urandom_range(0, 30);
                    queue_item(OP_WRITE, frame, ADR_CMP_LO, data, now);
                end else begin
                    data = ($urandom_range(0, 3) == 0) ? $urandom : now[63:32];
                    queue_item(OP_WRITE, frame, ADR_CMP_HI, data, now);
                end
            end else begin
                queue_item(2'($urandom_range(0, 3)), 1'($urandom),
                           ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 24))
                                                       : 12'($urandom),
                           $urandom, {$urandom, $urandom});
            end
        end
    endtask

    // Sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive_items
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(step_watchdog(cur_item));
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_tdata  <= {4'd0, cur_item.count, cur_item.wdata, cur_item.addr};
                    s_tuser  <= {cur_item.frame, cur_item.op};
                    offer    = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                s_tvalid <= offer;
            end
        end
    end

    // Receiver: stall pattern is redrawn at random periodically; one long hold-off
    int          rx_cycles = 0;
    int          hold_left = 0;
    logic [1:0]  ready_mode = 2'd0;

    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles == HOLD_START) hold_left = HOLD_LEN;
            if (rx_cycles % 64 == 0) ready_mode = 2'($urandom_range(0, 3));
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    2'd0:    m_tready <= 1'b1;
                    2'd1:    m_tready <= 1'($urandom_range(0, 1));
                    2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rx_cycles[2];
                endcase
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR result %0d: %s got %h, want %h", results_checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer, data", m_tdata[31:0], 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.read_data)
                    report_mismatch("read_data", m_tdata[31:0], want.read_data);
                if (m_tdata[32] !== want.stage_one)
                    report_mismatch("stage_one_signal", 32'(m_tdata[32]), 32'(want.stage_one));
                if (m_tdata[33] !== want.stage_two)
                    report_mismatch("stage_two_signal", 32'(m_tdata[33]), 32'(want.stage_two));
            end
            results_checked++;
        end
    end

    // Ends the run if neither side moves for too long
    int idle_cycles = 0;

    always @(posedge aclk) begin : idle_watch
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("two_stage_watchdog_timer test failed");
                $finish;
            end
        end
    end

    initial begin
        queue_directed_items();
        queue_random_items(1425);
        total_items = pending_items.size();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (items_accepted < total_items) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (expected_results.size() > 0)
            report_mismatch("results missing, count", 32'd0, 32'(expected_results.size()));
        $display("Checked %0d results: %0d ticks, %0d reads, %0d writes.",
                 results_checked, n_ticks, n_reads, n_writes);
        $display("Stage one fired %0d times, stage two %0d times; %0d mismatches.",
                 n_stage_one, n_stage_two, mismatches);
        if (mismatches == 0) begin
            $display("two_stage_watchdog_timer test passed");
        end else begin
            $display("two_stage_watchdog_timer test failed");
        end
        $finish;
    end

endmodule

// File: two_stage_watchdog_timer.f
rtl/wdt_pkg.sv
rtl/wdt_decode.sv
rtl/wdt_core.sv
rtl/two_stage_watchdog_timer.sv
tb/two_stage_watchdog_timer_tb.sv
